// ----- src/dmtt_pkg.sv -----
// shared types and codes of the delayed message timer table
package dmtt_pkg;

    // operation codes on s_tuser
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_CANCEL  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_DELIVER = 2'd3;

    // status codes on m_tuser
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_CLAMPED = 2'd2;

    // command queue depth between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  task_id;
        logic [7:0]  msg_id;
        logic [15:0] ticks;
        logic        clamped;
    } dmtt_cmd_t;

    // one slot word in the slot memory
    typedef struct packed {
        logic [7:0]  task_id;
        logic [7:0]  msg_id;
        logic [15:0] ticks;
    } dmtt_slot_t;

    // one result item
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_msg;
        logic [7:0] out_task;
        logic       delivered;
    } dmtt_res_t;

endpackage

// ----- src/dmtt_ram.sv -----
// generic simple dual port ram with registered read
module dmtt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- src/dmtt_front.sv -----
// front end: accepts operations, clamps the delay and converts it to ticks
module dmtt_front
    import dmtt_pkg::*;
#(
    parameter int TICK_MS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        push,
    output dmtt_cmd_t   push_cmd,
    input  logic        q_full
);

    // divide by reciprocal multiply, exact for all 16-bit dividends
    localparam int SH = 16 + $clog2(TICK_MS);
    localparam int MW = 18;
    localparam int PW = SH + 16;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(TICK_MS) - 64'd1)
                                          / 64'(TICK_MS));
    localparam logic [15:0] TICK_MIN = 16'(TICK_MS);

    logic          stg_vld_reg, stg_vld_next;
    dmtt_cmd_t     stg_cmd_reg, stg_cmd_next;
    logic [PW-1:0] stg_prod_reg, stg_prod_next;
    logic [15:0]   delay_clamped;
    logic          accept;

    assign s_tready = !stg_vld_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = stg_vld_reg && !q_full;

    always_comb begin
        delay_clamped = (s_tdata[31:16] < TICK_MIN) ? TICK_MIN : s_tdata[31:16];
    end

    always_comb begin
        push_cmd       = stg_cmd_reg;
        push_cmd.ticks = stg_prod_reg[SH +: 16];
    end

    always_comb begin
        stg_vld_next  = stg_vld_reg;
        stg_cmd_next  = stg_cmd_reg;
        stg_prod_next = stg_prod_reg;
        if (push) begin
            stg_vld_next = 1'b0;
        end
        if (accept) begin
            stg_vld_next         = 1'b1;
            stg_cmd_next.func    = s_tuser;
            stg_cmd_next.task_id = s_tdata[7:0];
            stg_cmd_next.msg_id  = s_tdata[15:8];
            stg_cmd_next.ticks   = '0;
            stg_cmd_next.clamped = s_tdata[31:16] < TICK_MIN;
            stg_prod_next        = PW'(delay_clamped) * PW'(RECIP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg <= 1'b0;
        end else begin
            stg_vld_reg <= stg_vld_next;
        end
        stg_cmd_reg  <= stg_cmd_next;
        stg_prod_reg <= stg_prod_next;
    end

endmodule

// ----- src/dmtt_fifo.sv -----
// short command queue between front and back
module dmtt_fifo
    import dmtt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  dmtt_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output dmtt_cmd_t head_cmd
);

    dmtt_cmd_t          entry_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]     count_reg, count_next;

    assign full     = count_reg == QCW'(QDEPTH);
    assign empty    = count_reg == '0;
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/dmtt_back.sv -----
// back end: scans the slot table one slot a cycle and holds the result register
module dmtt_back
    import dmtt_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_empty,
    input  dmtt_cmd_t q_head,
    output logic      pop,
    output logic      m_tvalid,
    input  logic      m_tready,
    output dmtt_res_t m_res
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [SLOTS-1:0] busy_reg, busy_next;
    dmtt_cmd_t        cmd_reg, cmd_next;
    dmtt_res_t        res_reg, res_next;
    logic             out_vld_reg, out_vld_next;
    dmtt_res_t        out_reg, out_next;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    dmtt_slot_t       ram_wdata;
    logic [IW-1:0]    ram_raddr;
    dmtt_slot_t       ram_rdata;
    logic             cur_busy;
    logic             hit;

    dmtt_ram #(
        .WIDTH ($bits(dmtt_slot_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_vld_reg;
    assign m_res    = out_reg;
    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign cur_busy = busy_reg[idx_reg];

    // slot 0 is read while idle so its word is ready on the first scan cycle
    always_comb begin
        if (state_reg == S_SCAN && idx_reg != LAST) begin
            ram_raddr = idx_reg + 1'b1;
        end else begin
            ram_raddr = '0;
        end
    end

    always_comb begin
        case (cmd_reg.func)
            OP_INSERT:  hit = !cur_busy;
            OP_CANCEL:  hit = cur_busy && (ram_rdata.task_id == cmd_reg.task_id);
            OP_TICK:    hit = cur_busy && (ram_rdata.ticks != '0);
            OP_DELIVER: hit = cur_busy && (ram_rdata.ticks == '0);
            default:    hit = 1'b0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        busy_next    = busy_reg;
        cmd_next     = cmd_reg;
        res_next     = res_reg;
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = ram_rdata;

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    cmd_next  = q_head;
                    idx_next  = '0;
                    res_next  = '0;
                    // an insert that finds no free slot keeps this status
                    res_next.status = (q_head.func == OP_INSERT) ? ST_FULL : ST_OK;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST) begin
                    state_next = S_DONE;
                end
                if (hit) begin
                    case (cmd_reg.func)
                        OP_INSERT: begin
                            ram_we            = 1'b1;
                            ram_wdata.task_id = cmd_reg.task_id;
                            ram_wdata.msg_id  = cmd_reg.msg_id;
                            ram_wdata.ticks   = cmd_reg.ticks;
                            busy_next[idx_reg] = 1'b1;
                            res_next.status   = cmd_reg.clamped ? ST_CLAMPED : ST_OK;
                            state_next        = S_DONE;
                        end
                        OP_CANCEL: begin
                            busy_next[idx_reg] = 1'b0;
                            state_next         = S_DONE;
                        end
                        OP_TICK: begin
                            ram_we          = 1'b1;
                            ram_wdata.ticks = ram_rdata.ticks - 1'b1;
                        end
                        default: begin
                            busy_next[idx_reg] = 1'b0;
                            res_next.delivered = 1'b1;
                            res_next.out_task  = ram_rdata.task_id;
                            res_next.out_msg   = ram_rdata.msg_id;
                            state_next         = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next = 1'b1;
                    out_next     = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            busy_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            out_vld_reg <= out_vld_next;
        end
        idx_reg <= idx_next;
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

endmodule

// ----- src/delayed_message_timer_table_core.sv -----
// top level of the delayed message timer table
//
// usage
// - slave channel takes one operation per transfer: s_tuser selects insert,
//   cancel, tick or deliver; s_tdata carries task, message and delay in ms
// - master channel returns exactly one result transfer per operation, in
//   order: delivered flag and status on m_tuser, task and message on m_tdata
// - the front stage clamps the delay and turns it into ticks with one
//   reciprocal multiply, then hands the command to a two-entry queue
// - the back end walks the slot memory one slot per cycle; insert, cancel
//   and deliver stop at the first matching slot, tick visits all SLOTS slots
// - in the back end an item passes the idle pop, the slot walk and the result
//   stage in turn; the walk is paced by the single read port of the slot ram
// - from input transfer to result a command passes the front stage register,
//   the queue with any wait there, the slot walk and the result register
// - a stalled m_tready holds the result in the output register; the back end
//   finishes the next command and waits, and the queue then fills and drops
//   s_tready
// - reset clears all busy flags, the queue and the output valid; slot words
//   of free slots are never used, so the slot ram needs no clearing pass
module delayed_message_timer_table_core
    import dmtt_pkg::*;
#(
    parameter int SLOTS   = 8,
    parameter int TICK_MS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // operation input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // task_id[7:0], msg_id[15:8], delay_req[31:16]
    input  logic [1:0]  s_tuser,   // func[1:0]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_task[7:0], out_msg[15:8]
    output logic [2:0]  m_tuser    // delivered[0], status[2:1]
);

    logic      push;
    dmtt_cmd_t push_cmd;
    logic      q_full;
    logic      pop;
    logic      q_empty;
    dmtt_cmd_t q_head;
    dmtt_res_t res;

    // accept, clamp and convert delay to ticks
    dmtt_front #(
        .TICK_MS (TICK_MS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // decouples the front from a busy or stalled back end
    dmtt_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head_cmd (q_head)
    );

    // slot table walk and output register
    dmtt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res)
    );

    // pack the result fields onto the master channel
    assign m_tdata = {res.out_msg, res.out_task};
    assign m_tuser = {res.status, res.delivered};

endmodule

// ----- src/dmtt_checker.sv -----
// port level checks of the timer table result channel, bound to the top level
module dmtt_checker
    import dmtt_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // without a delivery the task and message fields are zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0)
        else $error("payload on a result without delivery");

    // a delivery always carries ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_OK)
        else $error("delivery with non-ok status");

    // status is never an undefined code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2:1] == ST_OK || m_tuser[2:1] == ST_FULL
                     || m_tuser[2:1] == ST_CLAMPED)
        else $error("undefined status code");

endmodule

bind delayed_message_timer_table_core dmtt_checker u_dmtt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/delayed_message_timer_table_core_test.sv -----
// self-checking testbench for the delayed message timer table core
`timescale 1ns / 100ps

module delayed_message_timer_table_core_test;
    import dmtt_pkg::*;

    localparam int SLOTS      = 8;
    localparam int TICK_MS    = 10;
    localparam int N_RANDOM   = 1050;
    localparam int IDLE_LIMIT = 3000;     // cycles without any transfer
    localparam int TAIL       = 4 * SLOTS + 16;
    localparam int MAX_PRINTS = 50;

    // timer table model plus the queue of results still owed by the block
    class dmtt_scoreboard;
        bit          busy[SLOTS];
        logic [7:0]  task_of[SLOTS];
        logic [7:0]  msg_of[SLOTS];
        logic [15:0] ticks_left[SLOTS];
        dmtt_res_t   owed_q[$];
        int          fails;
        int          n_checked;

        function void report(string what);
            fails++;
            if (fails <= MAX_PRINTS)
                $display("ERROR result %0d at %0t: %s", n_checked, $realtime, what);
        endfunction

        function void free_slot(int k);
            busy[k]       = 1'b0;
            task_of[k]    = '0;
            msg_of[k]     = '0;
            ticks_left[k] = '0;
        endfunction

        // apply one accepted operation to the table and queue its result
        function void note_op(logic [1:0] func, logic [7:0] tid, logic [7:0] mid,
                              logic [15:0] delay_req);
            dmtt_res_t   r;
            bit          clamped;
            logic [15:0] d;
            r = '0;
            r.status = ST_OK;
            case (func)
                OP_INSERT: begin
                    clamped = (delay_req < TICK_MS);
                    d = clamped ? 16'(TICK_MS) : delay_req;
                    // a full table wins over a clamped delay
                    r.status = ST_FULL;
                    for (int k = 0; k < SLOTS; k++) begin
                        if (!busy[k]) begin
                            busy[k]       = 1'b1;
                            task_of[k]    = tid;
                            msg_of[k]     = mid;
                            ticks_left[k] = 16'(d / TICK_MS);
                            r.status      = clamped ? ST_CLAMPED : ST_OK;
                            break;
                        end
                    end
                end
                OP_CANCEL: begin
                    for (int k = 0; k < SLOTS; k++) begin
                        if (busy[k] && task_of[k] == tid) begin
                            free_slot(k);
                            break;
                        end
                    end
                end
                OP_TICK: begin
                    for (int k = 0; k < SLOTS; k++)
                        if (busy[k] && ticks_left[k] != 0)
                            ticks_left[k] = ticks_left[k] - 16'd1;
                end
                default: begin
                    // deliver: lowest expired slot
                    for (int k = 0; k < SLOTS; k++) begin
                        if (busy[k] && ticks_left[k] == 0) begin
                            r.delivered = 1'b1;
                            r.out_task  = task_of[k];
                            r.out_msg   = msg_of[k];
                            free_slot(k);
                            break;
                        end
                    end
                end
            endcase
            owed_q.push_back(r);
        endfunction

        function void check_result(logic [15:0] data, logic [2:0] user);
            dmtt_res_t want;
            dmtt_res_t got;
            got.delivered = user[0];
            got.status    = user[2:1];
            got.out_task  = data[7:0];
            got.out_msg   = data[15:8];
            if (owed_q.size() == 0) begin
                report("result transfer with no operation outstanding");
                return;
            end
            want = owed_q.pop_front();
            if (got.delivered !== want.delivered)
                report($sformatf("delivered %b, want %b", got.delivered, want.delivered));
            if (got.out_task !== want.out_task)
                report($sformatf("out_task %h, want %h", got.out_task, want.out_task));
            if (got.out_msg !== want.out_msg)
                report($sformatf("out_msg %h, want %h", got.out_msg, want.out_msg));
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            n_checked++;
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    dmtt_scoreboard sb = new;

    int burst_left = 0;
    int idle_run   = 0;
    int rx_mode    = 0;
    int rx_left    = 0;
    int rx_phase   = 0;

    always #1 aclk = ~aclk;

    delayed_message_timer_table_core #(
        .SLOTS   (SLOTS),
        .TICK_MS (TICK_MS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // one operation transfer; valid stays high inside a burst, drops for gaps
    task automatic send_op(input logic [1:0] func, input logic [7:0] tid,
                           input logic [7:0] mid, input logic [15:0] delay_req);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {delay_req, mid, tid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_op(func, tid, mid, delay_req);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            burst_left = $urandom_range(0, 30);
        end else begin
            burst_left--;
        end
    endtask

    // hold the sender off until every owed result has been returned
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_q.size() != 0) @(posedge aclk);
    endtask

    // result side: check each transfer, stall on a changing pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 60);
        end else begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 99) < 70);
            2:       m_tready <= (rx_phase % 4 == 0);
            default: m_tready <= (rx_left < 5);   // long stall, then release
        endcase
    end

    // watchdog on cycles where neither side moves a transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= IDLE_LIMIT) begin
            $display("delayed_message_timer_table_core: mismatch");
            $finish;
        end
    end

    initial begin
        logic [1:0]  func;
        logic [7:0]  tid;
        logic [7:0]  mid;
        logic [15:0] dly;
        int          pick;
        int          k;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, clamping edges, full table, cancel and deliver cases
        send_op(OP_DELIVER, 8'h00, 8'h00, 16'h0000);   // nothing expired
        send_op(OP_TICK,    8'hff, 8'hff, 16'hffff);   // tick on empty table
        send_op(OP_CANCEL,  8'h00, 8'h00, 16'h0000);   // no matching task
        send_op(OP_INSERT,  8'h00, 8'h00, 16'd0);      // clamped from zero
        send_op(OP_INSERT,  8'hff, 8'hff, 16'd9);      // clamped just below a tick
        send_op(OP_INSERT,  8'h01, 8'h02, 16'd10);     // exactly one tick
        send_op(OP_INSERT,  8'h03, 8'h04, 16'd19);     // truncates to one tick
        send_op(OP_INSERT,  8'h05, 8'h06, 16'hffff);   // longest delay
        send_op(OP_INSERT,  8'hff, 8'h07, 16'd20);     // second slot of one task
        send_op(OP_INSERT,  8'h08, 8'h09, 16'd30);
        send_op(OP_INSERT,  8'h0a, 8'h0b, 16'd40);     // table now full
        send_op(OP_INSERT,  8'h0c, 8'h0d, 16'd0);      // full beats clamped
        send_op(OP_DELIVER, 8'h00, 8'h00, 16'h0000);   // full but none expired
        send_op(OP_TICK,    8'h00, 8'h00, 16'h0000);
        send_op(OP_CANCEL,  8'h00, 8'h55, 16'h1234);   // cancel an expired slot
        send_op(OP_CANCEL,  8'hff, 8'h00, 16'h0000);   // lowest slot of the task
        send_op(OP_DELIVER, 8'h00, 8'h00, 16'h0000);
        send_op(OP_TICK,    8'h00, 8'h00, 16'h0000);
        send_op(OP_CANCEL,  8'hff, 8'h00, 16'h0000);
        send_op(OP_CANCEL,  8'h05, 8'h00, 16'h0000);   // cancel a pending slot
        send_op(OP_DELIVER, 8'h00, 8'h00, 16'h0000);
        send_op(OP_DELIVER, 8'h00, 8'h00, 16'h0000);
        send_op(OP_INSERT,  8'haa, 8'h55, 16'd10);     // reuses a freed slot
        send_op(OP_TICK,    8'h00, 8'h00, 16'h0000);
        send_op(OP_DELIVER, 8'h00, 8'h00, 16'h0000);

        drain_results();

        // random mix, short delays so messages expire and get delivered
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2)
                drain_results();
            tid  = 8'($urandom);
            mid  = 8'($urandom);
            dly  = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                func = OP_INSERT;
                case ($urandom_range(0, 9))
                    0, 1, 2:    dly = 16'($urandom_range(0, TICK_MS - 1));
                    9:          ;   // full range delay
                    default:    dly = 16'($urandom_range(TICK_MS, 6 * TICK_MS));
                endcase
                // small task pool so that cancels find matches
                if ($urandom_range(0, 3) != 0)
                    tid = 8'($urandom_range(0, 15));
            end else if (pick < 48) begin
                func = OP_CANCEL;
                k = $urandom_range(0, SLOTS - 1);
                if (sb.busy[k] && $urandom_range(0, 4) != 0)
                    tid = sb.task_of[k];
                else if ($urandom_range(0, 1) == 1)
                    tid = 8'($urandom_range(0, 15));
            end else if (pick < 75) begin
                func = OP_TICK;
            end else begin
                func = OP_DELIVER;
            end
            send_op(func, tid, mid, dly);
        end

        drain_results();
        repeat (TAIL) @(posedge aclk);

        if (sb.fails == 0 && sb.owed_q.size() == 0)
            $display("delayed_message_timer_table_core: match");
        else
            $display("delayed_message_timer_table_core: mismatch");
        $finish;
    end

endmodule

// ----- delayed_message_timer_table_core.f -----
src/dmtt_pkg.sv
src/dmtt_ram.sv
src/dmtt_front.sv
src/dmtt_fifo.sv
src/dmtt_back.sv
src/delayed_message_timer_table_core.sv
src/dmtt_checker.sv
tb/delayed_message_timer_table_core_test.sv
